[rtl/sma_crossover_signal_macros.svh]
// Assertion macros for the crossover signal block.
`ifndef SMA_CROSSOVER_SIGNAL_MACROS_SVH
`define SMA_CROSSOVER_SIGNAL_MACROS_SVH
`ifndef SYNTHESIS
`define SMA_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define SMA_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SMA_ASSERT_IMP(label, clk, rst, a, c)
`define SMA_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

[rtl/smax_pkg.sv]
// Package with constants and register codes for the crossover signal block.
package smax_pkg;
  localparam int HISTORY_DEPTH_DEF = 32;
  localparam int PRICE_BITS_DEF = 32;
  localparam logic [1:0] REG_SHORT_LEN = 2'd0;
  localparam logic [1:0] REG_LONG_LEN = 2'd1;
  localparam logic [1:0] REG_REWARD = 2'd2;
  localparam logic signed [39:0] S40_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] S40_MIN = 40'sh80_0000_0000;
endpackage

[rtl/smax_ram.sv]
// Generic single port RAM with registered read.
module smax_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/sma_crossover_signal.sv]
// Top level of the dual moving average crossover signal block.
//
// Channel  Dir  Handshake        Payload
// s_axis   in   tvalid/tready    close_price, candle_time, asset_id
// m_axis   out  tvalid/tready    order fields
// apb      in   psel/penable     short_len, long_len, reward_ratio
//
// After reset a clearing pass zeroes the history. During warm-up, until
// as many candles as the larger effective window length have been seen,
// a candle is only written to the history. The window sums read the
// history RAM one entry a cycle, and both averages go through one
// shared bit-serial divider. The ratio product is built from four
// partial products. An order waits in the output register while the
// next candle is taken; the sequencer holds in its last step only while
// that register is still full.
module sma_crossover_signal #(
  parameter int HISTORY_DEPTH = smax_pkg::HISTORY_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: close_price[31:0], candle_time[63:32], asset_id[71:64]
  input  logic [71:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: order_time, order_asset, order_side, entry_price, stop_loss,
  // take_profit, then zero fill
  output logic [159:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import smax_pkg::*;
  `include "sma_crossover_signal_macros.svh"

  localparam int PRICE_BITS = PRICE_BITS_DEF;
  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int SW = PRICE_BITS + 5;       // sum of up to 31 prices
  localparam int DW = 40;                   // datapath of stop arithmetic
  localparam int CW = $clog2(SW + 1);
  localparam logic [AW-1:0] DEPTH_M1 = AW'(HISTORY_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_WRITE, ST_RD, ST_ACC, ST_DIV_S, ST_DIV_L,
    ST_STOP, ST_MUL, ST_DONE
  } state_t;

  state_t           state;
  logic [4:0]       short_len, long_len;
  logic [15:0]      reward_ratio;
  logic [AW-1:0]    write_pointer, ram_addr, rd_ptr;
  logic [4:0]       seen_count, need, ns, nl, rd_cnt;
  logic             short_above_flag;
  logic             ram_we;
  logic [PRICE_BITS-1:0] ram_wdata, ram_rdata, price;
  logic [31:0]      cur_time;
  logic [7:0]       cur_asset;
  logic [SW-1:0]    sum_s, sum_l, rem, quo, dvd;
  logic [CW-1:0]    div_cnt;
  logic             rd_valid;
  logic [5:0]       acc_cnt;
  logic [DW-1:0]    avg_s, avg_l;
  logic signed [DW+2:0] stop4, risk4;
  logic             side;
  logic [1:0]       mul_cnt;
  logic [DW+15:0]   mul_acc;
  logic [SW:0]      rem_try;

  assign pready = 1'b1;
  assign ns = (short_len == 5'd0) ? 5'd1 : short_len;
  assign nl = (long_len == 5'd0) ? 5'd1 : long_len;
  assign need = (ns > nl) ? ns : nl;
  assign s_axis_tready = (state == ST_IDLE);

  // Register read back.
  always_comb begin
    unique case (paddr[3:2])
      REG_SHORT_LEN: prdata = {27'd0, short_len};
      REG_LONG_LEN:  prdata = {27'd0, long_len};
      REG_REWARD:    prdata = {16'd0, reward_ratio};
      default:       prdata = 32'd0;
    endcase
  end

  // RAM port: clearing, candle write, then window reads.
  always_comb begin
    ram_we = (state == ST_CLEAR) || (state == ST_WRITE);
    ram_wdata = (state == ST_CLEAR) ? '0 : price;
    ram_addr = (state == ST_CLEAR || state == ST_WRITE) ? write_pointer : rd_ptr;
  end

  smax_ram #(.WIDTH(PRICE_BITS), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign rem_try = {rem, dvd[SW-1]} - {1'b0, (state == ST_DIV_S) ?
                   {{(SW-5){1'b0}}, ns} : {{(SW-5){1'b0}}, nl}};

  // Main sequencer: history update, window sums, division, order build.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      write_pointer <= '0;
      seen_count <= '0;
      short_above_flag <= 1'b0;
      m_axis_tvalid <= 1'b0;
      short_len <= 5'd10;
      long_len <= 5'd20;
      reward_ratio <= 16'd512;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_SHORT_LEN: short_len <= pwdata[4:0];
          REG_LONG_LEN:  long_len <= pwdata[4:0];
          REG_REWARD:    reward_ratio <= pwdata[15:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          write_pointer <= (write_pointer == DEPTH_M1) ? '0 : write_pointer + 1'b1;
          if (write_pointer == DEPTH_M1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            price <= s_axis_tdata[PRICE_BITS-1:0];
            cur_time <= s_axis_tdata[63:32];
            cur_asset <= s_axis_tdata[71:64];
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          rd_ptr <= write_pointer;
          write_pointer <= (write_pointer == DEPTH_M1) ? '0 : write_pointer + 1'b1;
          if (seen_count != 5'd31) seen_count <= seen_count + 1'b1;
          if (((seen_count == 5'd31) ? 5'd31 : seen_count + 1'b1) < need) begin
            state <= ST_IDLE;
          end else begin
            sum_s <= '0;
            sum_l <= '0;
            rd_cnt <= 5'd0;
            acc_cnt <= 6'd0;
            rd_valid <= 1'b0;
            state <= ST_RD;
          end
        end
        ST_RD: begin
          // Newest first; accumulate the read that returned this cycle.
          if (rd_valid) begin
            if (acc_cnt < {1'b0, ns}) sum_s <= sum_s + SW'(ram_rdata);
            if (acc_cnt < {1'b0, nl}) sum_l <= sum_l + SW'(ram_rdata);
            acc_cnt <= acc_cnt + 1'b1;
          end
          if (rd_valid && (acc_cnt + 1'b1 == {1'b0, need})) begin
            state <= ST_ACC;
          end
          rd_valid <= (rd_cnt < need);
          if (rd_cnt < need) begin
            rd_cnt <= rd_cnt + 1'b1;
            rd_ptr <= (rd_ptr == '0) ? DEPTH_M1 : rd_ptr - 1'b1;
          end
        end
        ST_ACC: begin
          dvd <= sum_s;
          rem <= '0;
          div_cnt <= '0;
          state <= ST_DIV_S;
        end
        ST_DIV_S, ST_DIV_L: begin
          // Restoring division, one quotient bit a cycle.
          if (div_cnt == CW'(SW - 1)) begin
            if (state == ST_DIV_S) begin
              avg_s <= DW'({dvd[SW-2:0], !rem_try[SW]});
              dvd <= sum_l;
              rem <= '0;
              div_cnt <= '0;
              state <= ST_DIV_L;
            end else begin
              avg_l <= DW'({dvd[SW-2:0], !rem_try[SW]});
              state <= ST_STOP;
            end
          end else begin
            if (!rem_try[SW]) begin
              rem <= rem_try[SW-1:0];
              dvd <= {dvd[SW-2:0], 1'b1};
            end else begin
              rem <= {rem[SW-2:0], dvd[SW-1]};
              dvd <= {dvd[SW-2:0], 1'b0};
            end
            div_cnt <= div_cnt + 1'b1;
          end
        end
        ST_STOP: begin
          logic signed [DW+2:0] g, c4, a, b, st;
          logic now;
          now = avg_s > avg_l;
          g = $signed({3'b0, (now ? avg_s - avg_l : avg_l - avg_s)});
          c4 = $signed({1'b0, (DW+2)'(price)}) <<< 2;
          short_above_flag <= now;
          side <= !now;
          if (now != short_above_flag) begin
            if (now) begin
              a = ($signed({3'b0, avg_l}) <<< 2) - g;
              b = c4 - (g <<< 1);
              st = (a < b) ? a : b;
              risk4 <= c4 - st;
            end else begin
              a = ($signed({3'b0, avg_s}) <<< 2) + g;
              b = c4 + (g <<< 1);
              st = (a > b) ? a : b;
              risk4 <= st - c4;
            end
            stop4 <= st;
            mul_acc <= '0;
            mul_cnt <= 2'd0;
            state <= ST_MUL;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_MUL: begin
          // rr*risk4 in 4 partial products of 9 bits each; risk4 stays below 2**35.
          mul_acc <= mul_acc + ((DW+16)'(reward_ratio) *
                     (DW+16)'(risk4[mul_cnt*9 +: 9]) << (mul_cnt*9));
          mul_cnt <= mul_cnt + 1'b1;
          if (mul_cnt == 2'd3) state <= ST_DONE;
        end
        ST_DONE: begin
          logic signed [DW+17:0] tp, sl, sr;
          sr = $signed({2'b0, mul_acc}) >>> 10;
          tp = side ? $signed((DW+18)'(price)) - sr : $signed((DW+18)'(price)) + sr;
          sl = (DW+18)'(stop4 >>> 2);
          // Load the order once the output register is free.
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata[31:0] <= cur_time;
            m_axis_tdata[39:32] <= cur_asset;
            m_axis_tdata[40] <= side;
            m_axis_tdata[72:41] <= 32'(price);
            m_axis_tdata[112:73] <= (sl > S40_MAX) ? S40_MAX : (sl < S40_MIN) ? S40_MIN
                                    : sl[39:0];
            m_axis_tdata[152:113] <= (tp > S40_MAX) ? S40_MAX : (tp < S40_MIN) ? S40_MIN
                                     : tp[39:0];
            m_axis_tdata[159:153] <= '0;
            m_axis_tvalid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SMA_ASSERT_IMP(a_ready_idle, clk, rst, s_axis_tready, state == ST_IDLE)
  `SMA_ASSERT_NXT(a_done_valid, clk, rst, state == ST_DONE, m_axis_tvalid)
  `SMA_ASSERT_IMP(a_div_cnt, clk, rst, state == ST_DIV_S || state == ST_DIV_L,
                  div_cnt < CW'(SW))
endmodule
